// ===== hw/rtl/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared widths, constants, register indexes and types of the line-follow
// PD steering block.
// ----------------------------------------------------------------------------
package lfs_pkg;

  // Sensor array and debounce
  localparam int NUM_SENSORS    = 8;
  localparam int CURVE_DEBOUNCE = 2;

  // Field widths
  localparam int SPEED_W = 10;
  localparam int DZ_W    = 3;
  localparam int CT_W    = 4;
  localparam int GAIN_W  = 16;
  localparam int GYRO_W  = 16;
  localparam int ERR_W   = 4;
  localparam int QUO_W   = ERR_W - 1;
  localparam int ERR_MAX = (1 << QUO_W) - 1;

  // Centroid divider
  localparam int CNT_W = $clog2(NUM_SENSORS + 1);
  localparam int WS_W  = $clog2(NUM_SENSORS * NUM_SENSORS) + 1;
  localparam int DV_W  = (WS_W > CNT_W + QUO_W) ? WS_W : CNT_W + QUO_W;
  localparam int K_W   = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  // Curve counter
  localparam int CURVE_W   = 8;
  localparam int CURVE_MAX = (1 << CURVE_W) - 1;

  // Correction arithmetic: floor(N / 1792) = floor(floor(N / 256) / 7)
  localparam int OP_W    = 19;
  localparam int MUL_W   = 2 * OP_W;
  localparam int FRAC_SH = 8;
  localparam int Q_LIM   = 16384;
  localparam int C_OFS   = 2341;
  localparam int U_OFS   = 7 * C_OFS;
  localparam int U_W     = 16;
  localparam int DIV7_SH = 19;
  localparam int DIV7_M  = ((1 << DIV7_SH) + 6) / 7;
  localparam int QD_W    = 14;
  localparam int WHEEL_W = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_SPEED  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_SPEED     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_THRESHOLD = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN         = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN         = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KGYRO_GAIN      = 4'd7;

  localparam logic [SPEED_W-1:0] RST_STRAIGHT_SPEED  = 10'd200;
  localparam logic [SPEED_W-1:0] RST_CURVE_SPEED     = 10'd150;
  localparam logic [SPEED_W-1:0] RST_SPEED_MAX       = 10'd400;
  localparam logic [DZ_W-1:0]    RST_DEADZONE        = 3'd1;
  localparam logic [CT_W-1:0]    RST_CURVE_THRESHOLD = 4'd5;
  localparam logic [GAIN_W-1:0]  RST_KP_GAIN         = 16'd2560;
  localparam logic [GAIN_W-1:0]  RST_KD_GAIN         = 16'd1280;
  localparam logic [GAIN_W-1:0]  RST_KGYRO_GAIN      = 16'd64;

  typedef struct packed {
    logic [SPEED_W-1:0] straight_speed;
    logic [SPEED_W-1:0] curve_speed;
    logic [SPEED_W-1:0] speed_max;
    logic [DZ_W-1:0]    deadzone;
    logic [CT_W-1:0]    curve_threshold;
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [GAIN_W-1:0]  kgyro_gain;
  } cfg_t;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    OP_P,
    OP_D,
    OP_G,
    OP_R
  } mul_op_e;

  typedef struct packed {
    logic           load;
    logic           div_en;
    logic [K_W-1:0] div_k;
    logic           decide;
    logic           mul_en;
    mul_op_e        mul_sel;
    logic           acc_load;
    logic           acc_add;
    logic           prev_upd;
    logic           sat_en;
    logic           finish;
  } dp_cmd_t;

  typedef struct packed {
    logic steer;
  } dp_status_t;

endpackage

// ===== hw/rtl/lfs_in_if.sv =====
// ----------------------------------------------------------------------------
// lfs_in_if
// Request channel carrying one tick of sensor bits, gyro rate and PD clear.
// ----------------------------------------------------------------------------
interface lfs_in_if;
  logic                                valid;
  logic                                ready;
  logic [lfs_pkg::NUM_SENSORS-1:0]     sensor_bits;
  logic signed [lfs_pkg::GYRO_W-1:0]   gyro_rate;
  logic                                clear_pd;

  modport source (output valid, sensor_bits, gyro_rate, clear_pd, input ready);
  modport sink   (input valid, sensor_bits, gyro_rate, clear_pd, output ready);
endinterface

// ===== hw/rtl/lfs_out_if.sv =====
// ----------------------------------------------------------------------------
// lfs_out_if
// Result channel carrying the wheel targets, line error and curve flag.
// ----------------------------------------------------------------------------
interface lfs_out_if;
  logic                              valid;
  logic                              ready;
  logic [lfs_pkg::SPEED_W-1:0]       left_target;
  logic [lfs_pkg::SPEED_W-1:0]       right_target;
  logic signed [lfs_pkg::ERR_W-1:0]  line_error;
  logic                              curve_active;

  modport source (output valid, left_target, right_target, line_error, curve_active,
                  input ready);
  modport sink   (input valid, left_target, right_target, line_error, curve_active,
                  output ready);
endinterface

// ===== hw/rtl/lfs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lfs_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lfs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lfs_pkg::CFG_IDX_W-1:0]      index;
  logic [lfs_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lfs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lfs_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lfs_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  lfs_cfg_if.sink       cfg_i,
  output lfs_pkg::cfg_t cfg_o
);

  lfs_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lfs_pkg::REG_STRAIGHT_SPEED:  cfg_d.straight_speed  = cfg_i.data[lfs_pkg::SPEED_W-1:0];
        lfs_pkg::REG_CURVE_SPEED:     cfg_d.curve_speed     = cfg_i.data[lfs_pkg::SPEED_W-1:0];
        lfs_pkg::REG_SPEED_MAX:       cfg_d.speed_max       = cfg_i.data[lfs_pkg::SPEED_W-1:0];
        lfs_pkg::REG_DEADZONE:        cfg_d.deadzone        = cfg_i.data[lfs_pkg::DZ_W-1:0];
        lfs_pkg::REG_CURVE_THRESHOLD: cfg_d.curve_threshold = cfg_i.data[lfs_pkg::CT_W-1:0];
        lfs_pkg::REG_KP_GAIN:         cfg_d.kp_gain         = cfg_i.data[lfs_pkg::GAIN_W-1:0];
        lfs_pkg::REG_KD_GAIN:         cfg_d.kd_gain         = cfg_i.data[lfs_pkg::GAIN_W-1:0];
        lfs_pkg::REG_KGYRO_GAIN:      cfg_d.kgyro_gain      = cfg_i.data[lfs_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.straight_speed  <= lfs_pkg::RST_STRAIGHT_SPEED;
      cfg_q.curve_speed     <= lfs_pkg::RST_CURVE_SPEED;
      cfg_q.speed_max       <= lfs_pkg::RST_SPEED_MAX;
      cfg_q.deadzone        <= lfs_pkg::RST_DEADZONE;
      cfg_q.curve_threshold <= lfs_pkg::RST_CURVE_THRESHOLD;
      cfg_q.kp_gain         <= lfs_pkg::RST_KP_GAIN;
      cfg_q.kd_gain         <= lfs_pkg::RST_KD_GAIN;
      cfg_q.kgyro_gain      <= lfs_pkg::RST_KGYRO_GAIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/lfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfs_ctrl
// Sequencer: centroid division steps, multiply-accumulate steps, result
// hand-off into the output register.
// ----------------------------------------------------------------------------
module lfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  lfs_pkg::dp_status_t status_i,
  output lfs_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_MP   = 4'd3;
  localparam logic [3:0] S_MD   = 4'd4;
  localparam logic [3:0] S_MG   = 4'd5;
  localparam logic [3:0] S_MA   = 4'd6;
  localparam logic [3:0] S_SAT  = 4'd7;
  localparam logic [3:0] S_RC   = 4'd8;
  localparam logic [3:0] S_WH   = 4'd9;

  logic [3:0]              state_d, state_q;
  logic [lfs_pkg::K_W-1:0] k_d, k_q;
  logic                    out_valid_d, out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          k_d        = lfs_pkg::K_W'(lfs_pkg::QUO_W - 1);
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        cmd_o.div_k  = k_q;
        if (k_q == '0) begin
          state_d = S_DEC;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        state_d      = status_i.steer ? S_MP : S_WH;
      end
      S_MP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lfs_pkg::OP_P;
        state_d       = S_MD;
      end
      S_MD: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = lfs_pkg::OP_D;
        cmd_o.acc_load = 1'b1;
        cmd_o.prev_upd = 1'b1;
        state_d        = S_MG;
      end
      S_MG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lfs_pkg::OP_G;
        cmd_o.acc_add = 1'b1;
        state_d       = S_MA;
      end
      S_MA: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat_en = 1'b1;
        state_d      = S_RC;
      end
      S_RC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lfs_pkg::OP_R;
        state_d       = S_WH;
      end
      S_WH: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/lfs_dp.sv =====
// ----------------------------------------------------------------------------
// lfs_dp
// Datapath: weighted sum, restoring divider, PD state, shared multiplier with
// accumulator, floor scaling and wheel clamping, result register.
// ----------------------------------------------------------------------------
module lfs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfs_pkg::cfg_t                       cfg_i,
  input  lfs_pkg::dp_cmd_t                    cmd_i,
  input  logic [lfs_pkg::NUM_SENSORS-1:0]     sensor_bits_i,
  input  logic signed [lfs_pkg::GYRO_W-1:0]   gyro_rate_i,
  input  logic                                clear_pd_i,
  output lfs_pkg::dp_status_t                 status_o,
  output logic [lfs_pkg::SPEED_W-1:0]         left_target_o,
  output logic [lfs_pkg::SPEED_W-1:0]         right_target_o,
  output logic signed [lfs_pkg::ERR_W-1:0]    line_error_o,
  output logic                                curve_active_o
);

  // captured item and divider state
  logic [lfs_pkg::NUM_SENSORS-1:0]   bits_q;
  logic signed [lfs_pkg::GYRO_W-1:0] gyro_q;
  logic [lfs_pkg::CNT_W-1:0]         cnt_q;
  logic [lfs_pkg::DV_W-1:0]          rem_q;
  logic [lfs_pkg::QUO_W-1:0]         quo_q;
  logic                              neg_q, sat_q, lost_q;

  // PD and curve state
  logic signed [lfs_pkg::ERR_W-1:0]  prev_q, err_q;
  logic [lfs_pkg::CURVE_W-1:0]       cc_q;
  logic                              steer_q, curve_q;

  // arithmetic
  logic signed [lfs_pkg::MUL_W-1:0]  mul_q, acc_q;
  logic [lfs_pkg::U_W-1:0]           u_q;

  // result register
  logic [lfs_pkg::SPEED_W-1:0]       left_q, right_q;
  logic signed [lfs_pkg::ERR_W-1:0]  res_err_q;
  logic                              res_curve_q;

  // weighted sum and count of the incoming sensor word
  logic signed [lfs_pkg::WS_W-1:0]   wsum, wabs;
  logic [lfs_pkg::CNT_W-1:0]         cnt;
  logic [lfs_pkg::DV_W-1:0]          mag, cnt_ext;

  always_comb begin
    wsum = '0;
    cnt  = '0;
    for (int i = 0; i < lfs_pkg::NUM_SENSORS; i++) begin
      if (sensor_bits_i[i]) begin
        wsum = wsum + lfs_pkg::WS_W'(2 * i - (lfs_pkg::NUM_SENSORS - 1));
        cnt  = cnt + lfs_pkg::CNT_W'(1);
      end
    end
    wabs    = wsum[lfs_pkg::WS_W-1] ? -wsum : wsum;
    mag     = lfs_pkg::DV_W'($unsigned(wabs));
    cnt_ext = lfs_pkg::DV_W'(cnt);
  end

  // one quotient bit per step
  logic [lfs_pkg::DV_W-1:0] div_sub;
  logic                     div_ge;

  always_comb begin
    div_sub = lfs_pkg::DV_W'(cnt_q) << cmd_i.div_k;
    div_ge  = rem_q >= div_sub;
  end

  // error, deadzone and curve decision
  logic [lfs_pkg::QUO_W-1:0]        err_mag, aerr;
  logic signed [lfs_pkg::ERR_W-1:0] err_dec;
  logic                             in_dz, steer, curve_hit;
  logic [lfs_pkg::CURVE_W-1:0]      cc_next;

  always_comb begin
    err_mag = sat_q ? lfs_pkg::QUO_W'(lfs_pkg::ERR_MAX) : quo_q;
    aerr    = lost_q ? '0 : err_mag;
    err_dec = neg_q ? -$signed({1'b0, aerr}) : $signed({1'b0, aerr});
    in_dz   = {1'b0, aerr} <= {1'b0, cfg_i.deadzone};
    steer   = !lost_q && !in_dz;
    curve_hit = bits_q[0] || bits_q[lfs_pkg::NUM_SENSORS-1] ||
                (lfs_pkg::CT_W'(aerr) >= cfg_i.curve_threshold);
    if (!curve_hit) begin
      cc_next = '0;
    end else if (cc_q == lfs_pkg::CURVE_W'(lfs_pkg::CURVE_MAX)) begin
      cc_next = cc_q;
    end else begin
      cc_next = cc_q + 1'b1;
    end
  end

  assign status_o.steer = steer;

  // multiplier operands
  logic [lfs_pkg::QUO_W-1:0]         eabs;
  logic [2*lfs_pkg::QUO_W-1:0]       esq;
  logic signed [lfs_pkg::OP_W-1:0]   sq_x, d_x, g_x, op_a, op_b;
  logic signed [lfs_pkg::ERR_W:0]    d;

  always_comb begin
    eabs = err_q[lfs_pkg::ERR_W-1] ? lfs_pkg::QUO_W'(-err_q) : err_q[lfs_pkg::QUO_W-1:0];
    esq  = eabs * eabs;
    sq_x = lfs_pkg::OP_W'(esq);
    d    = (lfs_pkg::ERR_W + 1)'(err_q) - (lfs_pkg::ERR_W + 1)'(prev_q);
    d_x  = lfs_pkg::OP_W'(d);
    g_x  = lfs_pkg::OP_W'(gyro_q);
    unique case (cmd_i.mul_sel)
      lfs_pkg::OP_P: begin
        op_a = lfs_pkg::OP_W'(cfg_i.kp_gain);
        op_b = err_q[lfs_pkg::ERR_W-1] ? -sq_x : sq_x;
      end
      lfs_pkg::OP_D: begin
        op_a = lfs_pkg::OP_W'(cfg_i.kd_gain);
        op_b = (d_x <<< 3) - d_x;
      end
      lfs_pkg::OP_G: begin
        op_a = lfs_pkg::OP_W'(cfg_i.kgyro_gain);
        op_b = g_x - (g_x <<< 3);
      end
      lfs_pkg::OP_R: begin
        op_a = lfs_pkg::OP_W'(lfs_pkg::DIV7_M);
        op_b = lfs_pkg::OP_W'(u_q);
      end
    endcase
  end

  // floor by 256, limit, offset so that the divide by 7 runs on a positive value
  logic signed [lfs_pkg::MUL_W-1:0] q_sh;
  logic signed [lfs_pkg::U_W-1:0]   q_lim;
  logic signed [lfs_pkg::U_W:0]     u_s;

  always_comb begin
    q_sh = acc_q >>> lfs_pkg::FRAC_SH;
    if (q_sh > lfs_pkg::MUL_W'(lfs_pkg::Q_LIM - 1)) begin
      q_lim = lfs_pkg::U_W'(lfs_pkg::Q_LIM - 1);
    end else if (q_sh < -lfs_pkg::MUL_W'(lfs_pkg::Q_LIM)) begin
      q_lim = -lfs_pkg::U_W'(lfs_pkg::Q_LIM);
    end else begin
      q_lim = q_sh[lfs_pkg::U_W-1:0];
    end
    u_s = (lfs_pkg::U_W + 1)'(q_lim) + (lfs_pkg::U_W + 1)'(lfs_pkg::U_OFS);
  end

  // correction and clamped wheel targets
  logic [lfs_pkg::QD_W-1:0]            qd;
  logic signed [lfs_pkg::WHEEL_W-1:0]  corr, base_x, max_x, lt, rt;
  logic [lfs_pkg::SPEED_W-1:0]         base, lt_c, rt_c;

  always_comb begin
    qd     = mul_q[lfs_pkg::DIV7_SH +: lfs_pkg::QD_W];
    corr   = $signed(lfs_pkg::WHEEL_W'(qd)) - lfs_pkg::WHEEL_W'(lfs_pkg::C_OFS);
    base   = curve_q ? cfg_i.curve_speed : cfg_i.straight_speed;
    base_x = $signed(lfs_pkg::WHEEL_W'(base));
    max_x  = $signed(lfs_pkg::WHEEL_W'(cfg_i.speed_max));
    lt     = base_x + corr;
    rt     = base_x - corr;
    if (lt < 0) begin
      lt_c = '0;
    end else if (lt > max_x) begin
      lt_c = cfg_i.speed_max;
    end else begin
      lt_c = lt[lfs_pkg::SPEED_W-1:0];
    end
    if (rt < 0) begin
      rt_c = '0;
    end else if (rt > max_x) begin
      rt_c = cfg_i.speed_max;
    end else begin
      rt_c = rt[lfs_pkg::SPEED_W-1:0];
    end
  end

  // PD and curve state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cc_q   <= '0;
    end else begin
      priority if (cmd_i.load && clear_pd_i) begin
        prev_q <= '0;
      end else if (cmd_i.decide && !lost_q && in_dz) begin
        prev_q <= '0;
      end else if (cmd_i.prev_upd) begin
        prev_q <= err_q;
      end
      if (cmd_i.decide && steer) begin
        cc_q <= cc_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bits_q <= sensor_bits_i;
      gyro_q <= gyro_rate_i;
      cnt_q  <= cnt;
      rem_q  <= mag;
      quo_q  <= '0;
      neg_q  <= wsum[lfs_pkg::WS_W-1];
      sat_q  <= mag >= (cnt_ext << lfs_pkg::QUO_W);
      lost_q <= (cnt == '0) || (cnt == lfs_pkg::CNT_W'(lfs_pkg::NUM_SENSORS));
    end
    if (cmd_i.div_en && div_ge) begin
      rem_q               <= rem_q - div_sub;
      quo_q[cmd_i.div_k]  <= 1'b1;
    end
    if (cmd_i.decide) begin
      err_q   <= err_dec;
      steer_q <= steer;
      curve_q <= steer && (cc_next >= lfs_pkg::CURVE_W'(lfs_pkg::CURVE_DEBOUNCE));
    end
    if (cmd_i.mul_en) begin
      mul_q <= op_a * op_b;
    end
    if (cmd_i.acc_load) begin
      acc_q <= mul_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + mul_q;
    end
    if (cmd_i.sat_en) begin
      u_q <= u_s[lfs_pkg::U_W-1:0];
    end
    if (cmd_i.finish) begin
      res_err_q   <= err_q;
      res_curve_q <= curve_q;
      left_q      <= steer_q ? lt_c : cfg_i.straight_speed;
      right_q     <= steer_q ? rt_c : cfg_i.straight_speed;
    end
  end

  assign left_target_o  = left_q;
  assign right_target_o = right_q;
  assign line_error_o   = res_err_q;
  assign curve_active_o = res_curve_q;

endmodule

// ===== hw/rtl/line_follow_pd_steering.sv =====
// ----------------------------------------------------------------------------
// line_follow_pd_steering
// Line follower steering: weighted centroid of the sensor bits, PD law with
// quadratic proportional term and gyro damping, debounced curve speed.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    sensor_bits, gyro_rate, clear_pd
//   out_o    out  valid/ready    left_target, right_target, line_error,
//                                curve_active
//   cfg_i    in   valid/ready    index, data (ready always high)
//
// Sequence: one request at a time. A steered request runs 3 divider steps
// for the centroid, 4 steps on the single shared 19x19 multiplier and
// accumulator, limit and divide by 7 through the same multiplier, then the
// wheel clamp. Lost line, crossing and deadzone requests skip the
// multiplier.
// Reset: asynchronous, active low; restores register defaults and clears the
// PD error history and curve counter. No clearing pass.
// Stalls: a finished result sits in the output register while the next
// request is accepted and computed; only the final hand-off waits on out_o.
// ----------------------------------------------------------------------------
module line_follow_pd_steering (
  input  logic       clk_i,
  input  logic       rst_ni,
  lfs_in_if.sink     in_i,
  lfs_out_if.source  out_o,
  lfs_cfg_if.sink    cfg_i
);

  lfs_pkg::cfg_t       cfg;
  lfs_pkg::dp_cmd_t    cmd;
  lfs_pkg::dp_status_t status;

  // register file
  lfs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // sequencer: owns the input ready and the output valid
  lfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and the result payload
  lfs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sensor_bits_i  (in_i.sensor_bits),
    .gyro_rate_i    (in_i.gyro_rate),
    .clear_pd_i     (in_i.clear_pd),
    .status_o       (status),
    .left_target_o  (out_o.left_target),
    .right_target_o (out_o.right_target),
    .line_error_o   (out_o.line_error),
    .curve_active_o (out_o.curve_active)
  );

  // a request is followed by busy cycles: never two accepts in a row
  a_no_back_to_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while previous one still in work");

  // the saturated centroid never reaches the most negative code
  a_err_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.line_error >= -lfs_pkg::ERR_MAX))
    else $error("line error outside the centroid range");

  // curve speed only on a steered tick, and curve results obey the clamp
  a_curve_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.curve_active) |->
      (out_o.line_error != '0) &&
      (out_o.left_target <= cfg.speed_max) && (out_o.right_target <= cfg.speed_max))
    else $error("curve result with zero error or unclamped target");

endmodule
